// File: rtl/itaf_pkg.sv
// shared types, constants and sizing for the integer to ascii formatter
package itaf_pkg;

	// number width in bits, legal range 8 to 64
	localparam int unsigned VALUE_WIDTH = 32;
	// width of the value field on the input word
	localparam int unsigned IN_WIDTH = 32;

	// digits of the largest unsigned number: floor(w * log10(2)) + 1
	localparam int unsigned DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int unsigned HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int unsigned NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
	localparam int unsigned BCD_W = NUM_DIGITS * 4;
	localparam int unsigned STEP_CNT_W = $clog2(VALUE_WIDTH);

	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef struct packed {
		logic [IN_WIDTH-1:0] value;
		logic                mode;
		logic                twos_comp;
	} number_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} text_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sign_out;
		logic dabble;
		logic find;
		logic digit_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic neg;
		logic hex;
		logic step_last;
		logic idx_zero;
	} status_t;

endpackage

// File: rtl/itaf_ctrl.sv
// sequencing state machine of the integer to ascii formatter
module itaf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  itaf_pkg::status_t status,
	output itaf_pkg::cmd_t    cmd,
	output logic              busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SIGN = 5'b00010,
		ST_CONV = 5'b00100,
		ST_FIND = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				// minus sign goes out while nothing else is moving
				cmd.sign_out = status.neg;
				state_d = status.hex ? ST_FIND : ST_CONV;
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (status.step_last) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.digit_out = 1'b1;
				if (status.idx_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/itaf_dpath.sv
// magnitude, double dabble digit register and character output of the formatter
module itaf_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  itaf_pkg::number_t number,
	input  itaf_pkg::cmd_t    cmd,
	output itaf_pkg::status_t status,
	output itaf_pkg::text_t   text,
	output logic              text_strobe
);

	localparam int unsigned VW = itaf_pkg::VALUE_WIDTH;
	localparam int unsigned BW = itaf_pkg::BCD_W;
	localparam int unsigned ND = itaf_pkg::NUM_DIGITS;
	localparam int unsigned IW = itaf_pkg::DIGIT_IDX_W;
	localparam int unsigned CW = itaf_pkg::STEP_CNT_W;

	logic [VW-1:0]   mag_q;
	logic [BW-1:0]   bcd_q;
	logic [CW-1:0]   step_q;
	logic [IW-1:0]   idx_q;
	logic            neg_q;
	logic            hex_q;
	itaf_pkg::text_t text_q;
	logic            strobe_q;

	logic [VW+itaf_pkg::IN_WIDTH-1:0] wide;
	logic [VW-1:0]   raw;
	logic            neg_in;
	logic [VW-1:0]   mag_in;
	logic [3:0]      digit [ND];
	logic [BW-1:0]   bcd_adj;
	logic [IW-1:0]   top_idx;
	logic [3:0]      cur_digit;

	// bits above the number width are dropped
	assign wide   = (VW + itaf_pkg::IN_WIDTH)'(number.value);
	assign raw    = wide[VW-1:0];
	assign neg_in = number.twos_comp & raw[VW-1];
	assign mag_in = neg_in ? VW'(~raw + VW'(1)) : raw;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			digit[i] = bcd_q[i*4 +: 4];
			bcd_adj[i*4 +: 4] = (digit[i] >= 4'd5) ? 4'(digit[i] + 4'd3) : digit[i];
		end
	end

	// highest nonzero digit, zero when all are zero
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < ND; i++) begin
			if (digit[i] != 4'd0) begin
				top_idx = IW'(i);
			end
		end
	end

	assign cur_digit = digit[idx_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= mag_in;
			neg_q  <= neg_in;
			hex_q  <= (number.mode == itaf_pkg::MODE_HEX);
			step_q <= '0;
			bcd_q  <= (number.mode == itaf_pkg::MODE_HEX) ? BW'(mag_in) : '0;
		end else if (cmd.dabble) begin
			bcd_q  <= {bcd_adj[BW-2:0], mag_q[VW-1]};
			mag_q  <= mag_q << 1;
			step_q <= CW'(step_q + 1'b1);
		end
		if (cmd.find) begin
			idx_q <= top_idx;
		end else if (cmd.digit_out) begin
			idx_q <= IW'(idx_q - 1'b1);
		end
		if (cmd.sign_out) begin
			text_q.char_code <= itaf_pkg::CHAR_MINUS;
			text_q.last      <= 1'b0;
		end else begin
			text_q.char_code <= itaf_pkg::DIGIT_CHARS[cur_digit];
			text_q.last      <= (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.sign_out | cmd.digit_out;
		end
	end

	assign status.neg       = neg_q;
	assign status.hex       = hex_q;
	assign status.step_last = (step_q == CW'(VW - 1));
	assign status.idx_zero  = (idx_q == '0);

	assign text        = text_q;
	assign text_strobe = strobe_q;

endmodule

// File: rtl/integer_to_ascii_formatter_core.sv
// top level of the integer to ascii formatter: decimal or uppercase hex text, msd first
// the start cycle loads the number, the sign state registers the minus sign (negative only), digits leave one per cycle
// decimal: load, sign, VALUE_WIDTH double dabble steps, search, then the digits
// hex: load, sign, search, then the digits, with no double dabble steps
// the double dabble shift takes one bit per cycle; busy drops before the last character leaves
// arst_n clears the state machine and the strobe; characters leave with no backpressure
module integer_to_ascii_formatter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  itaf_pkg::number_t number,
	output itaf_pkg::text_t   text,
	output logic              text_strobe
);

	// command and status between the sequencer and the datapath
	itaf_pkg::cmd_t    cmd;
	itaf_pkg::status_t status;

	// sequencer: load, optional sign, conversion steps (decimal only), digit search, emission
	itaf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: magnitude, bcd digits and the registered character word
	itaf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.number      (number),
		.cmd         (cmd),
		.status      (status),
		.text        (text),
		.text_strobe (text_strobe)
	);

`ifndef ASSERT_OFF
	// a taken word always makes the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start");

	// the final character shows up only after the sequencer has gone idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		text_strobe && text.last |-> !busy)
		else $error("last character while still busy");

	// any character that is not last belongs to a number still in progress
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		text_strobe && !text.last |-> busy)
		else $error("non-final character while idle");

	// datapath commands never overlap
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping datapath commands");
`endif

endmodule
